@@ rtl/prqs_pkg.sv @@
// ----------------------------------------------------------------------------
// prqs_pkg: shared types and constants
// Payload structs, request codes, sequencer states and memory write enables.
// ----------------------------------------------------------------------------
package prqs_pkg;

  localparam int unsigned PrioLevelsDef = 32;
  localparam int unsigned TaskSlotsDef  = 64;
  localparam int unsigned TaskW         = 6;
  localparam int unsigned PrioReqW      = 8;
  localparam int unsigned MaskW         = 32;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_PEEK   = 2'd2,
    REQ_SCHED  = 2'd3
  } req_e;

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_ENQ_RD   = 8'b0000_0010,
    ST_ENQ_WR   = 8'b0000_0100,
    ST_DEQ_RD   = 8'b0000_1000,
    ST_DEQ_WR   = 8'b0001_0000,
    ST_PICK_RD  = 8'b0010_0000,
    ST_PICK_DEC = 8'b0100_0000,
    ST_DONE     = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic [1:0]          req_type;
    logic [TaskW-1:0]    task_id;
    logic [PrioReqW-1:0] priority_req;
    logic                current_runs;
  } in_t;

  typedef struct packed {
    logic             accepted;
    logic             chosen_valid;
    logic [TaskW-1:0] chosen_task;
    logic             switched;
    logic             previous_valid;
    logic [TaskW-1:0] previous_task;
    logic [MaskW-1:0] ready_mask;
  } out_t;

  typedef struct packed {
    logic next_we;
    logic prev_we;
    logic prio_we;
  } slot_we_t;

  typedef struct packed {
    logic head_we;
    logic tail_we;
  } queue_we_t;

endpackage

@@ rtl/prqs_slot_mem.sv @@
// ----------------------------------------------------------------------------
// prqs_slot_mem: per-slot link and priority memory
// Next link, previous link and stored priority; the next link has its own write
// address, the other two share one, and all share a registered read port.
// ----------------------------------------------------------------------------
module prqs_slot_mem
  import prqs_pkg::*;
#(
  parameter int unsigned SlotW = 6,
  parameter int unsigned PrioW = 5
) (
  input  logic             clk_i,
  input  slot_we_t         we_i,
  input  logic [SlotW-1:0] next_waddr_i,
  input  logic [SlotW:0]   next_wdata_i,
  input  logic [SlotW-1:0] pp_waddr_i,
  input  logic [SlotW:0]   prev_wdata_i,
  input  logic [PrioW-1:0] prio_wdata_i,
  input  logic [SlotW-1:0] raddr_i,
  output logic [SlotW:0]   next_rdata_o,
  output logic [SlotW:0]   prev_rdata_o,
  output logic [PrioW-1:0] prio_rdata_o
);

  localparam int unsigned Depth = 2 ** SlotW;

  logic [SlotW:0]   next_mem [Depth];
  logic [SlotW:0]   prev_mem [Depth];
  logic [PrioW-1:0] prio_mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i.next_we) begin
      next_mem[next_waddr_i] <= next_wdata_i;
    end
    if (we_i.prev_we) begin
      prev_mem[pp_waddr_i] <= prev_wdata_i;
    end
    if (we_i.prio_we) begin
      prio_mem[pp_waddr_i] <= prio_wdata_i;
    end
    next_rdata_o <= next_mem[raddr_i];
    prev_rdata_o <= prev_mem[raddr_i];
    prio_rdata_o <= prio_mem[raddr_i];
  end

endmodule

@@ rtl/prqs_queue_mem.sv @@
// ----------------------------------------------------------------------------
// prqs_queue_mem: per-priority head and tail memory
// One write and one registered read port for each of head and tail.
// ----------------------------------------------------------------------------
module prqs_queue_mem
  import prqs_pkg::*;
#(
  parameter int unsigned SlotW = 6,
  parameter int unsigned PrioW = 5
) (
  input  logic             clk_i,
  input  queue_we_t        we_i,
  input  logic [PrioW-1:0] head_waddr_i,
  input  logic [SlotW-1:0] head_wdata_i,
  input  logic [PrioW-1:0] tail_waddr_i,
  input  logic [SlotW-1:0] tail_wdata_i,
  input  logic [PrioW-1:0] head_raddr_i,
  input  logic [PrioW-1:0] tail_raddr_i,
  output logic [SlotW-1:0] head_rdata_o,
  output logic [SlotW-1:0] tail_rdata_o
);

  localparam int unsigned Depth = 2 ** PrioW;

  logic [SlotW-1:0] head_mem [Depth];
  logic [SlotW-1:0] tail_mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i.head_we) begin
      head_mem[head_waddr_i] <= head_wdata_i;
    end
    if (we_i.tail_we) begin
      tail_mem[tail_waddr_i] <= tail_wdata_i;
    end
    head_rdata_o <= head_mem[head_raddr_i];
    tail_rdata_o <= tail_mem[tail_raddr_i];
  end

endmodule

@@ rtl/priority_ready_queue_scheduler_top.sv @@
// ----------------------------------------------------------------------------
// priority_ready_queue_scheduler_top: bitmap priority ready-queue scheduler
// One FIFO ready queue per priority, kept as doubly linked task slots in
// memory, with a nonempty bitmap for picking the highest queue.
// ----------------------------------------------------------------------------
// The block takes one request transaction at a time and returns exactly one
// result transaction for it. A rejected request goes straight to the result
// step; add and remove run one link update each, peek reads the top head, and
// schedule stops after the pick when it is already the current task, else
// dequeues it, first requeueing the running current task when needed.
// Every link update is a read through the registered memory read ports and a
// write-back; a schedule chains pick, optional requeue and dequeue through them.
// A finished result sits in an output register, so a stalled consumer does not
// block accepting the next request; that result then waits in the done state,
// holding off further requests. Link and head/tail storage needs no clearing
// after reset; of the queue state only the slot-ready bits and bitmap reset.
module priority_ready_queue_scheduler_top
  import prqs_pkg::*;
#(
  parameter int unsigned PRIORITY_LEVELS = PrioLevelsDef,
  parameter int unsigned TASK_SLOTS      = TaskSlotsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam int unsigned SlotW     = $clog2(TASK_SLOTS);
  localparam int unsigned PrioW     = $clog2(PRIORITY_LEVELS);
  localparam int unsigned SlotDepth = 2 ** SlotW;

  // Sequencer and architectural state
  state_e                     state_q, state_d;
  in_t                        req_q, req_d;
  out_t                       res_q, res_d;
  out_t                       out_q, out_d;
  logic                       out_valid_q, out_valid_d;
  logic [SlotW-1:0]           op_t_q, op_t_d;
  logic [PrioW-1:0]           op_p_q, op_p_d;
  logic [SlotW-1:0]           pick_q, pick_d;
  logic                       sched_q, sched_d;
  logic [PRIORITY_LEVELS-1:0] ready_bits_q, ready_bits_d;
  logic [SlotDepth-1:0]       slot_ready_q, slot_ready_d;
  logic [SlotW-1:0]           cur_q, cur_d;
  logic                       cur_present_q, cur_present_d;

  // Memory ports
  slot_we_t         slot_we;
  logic [SlotW-1:0] next_waddr, pp_waddr, slot_raddr;
  logic [SlotW:0]   next_wdata, prev_wdata, next_rd, prev_rd;
  logic [PrioW-1:0] prio_wdata, prio_rd;
  queue_we_t        queue_we;
  logic [PrioW-1:0] head_waddr, tail_waddr, head_raddr, tail_raddr;
  logic [SlotW-1:0] head_wdata, tail_wdata, head_rd, tail_rd;

  logic             in_acc;
  logic [SlotW-1:0] in_slot;
  logic             in_ok;
  logic [PrioW-1:0] in_prio;
  logic [PrioW-1:0] top_prio;

  prqs_slot_mem #(.SlotW(SlotW), .PrioW(PrioW)) u_slot_mem (
    .clk_i        (clk_i),
    .we_i         (slot_we),
    .next_waddr_i (next_waddr),
    .next_wdata_i (next_wdata),
    .pp_waddr_i   (pp_waddr),
    .prev_wdata_i (prev_wdata),
    .prio_wdata_i (prio_wdata),
    .raddr_i      (slot_raddr),
    .next_rdata_o (next_rd),
    .prev_rdata_o (prev_rd),
    .prio_rdata_o (prio_rd)
  );

  prqs_queue_mem #(.SlotW(SlotW), .PrioW(PrioW)) u_queue_mem (
    .clk_i        (clk_i),
    .we_i         (queue_we),
    .head_waddr_i (head_waddr),
    .head_wdata_i (head_wdata),
    .tail_waddr_i (tail_waddr),
    .tail_wdata_i (tail_wdata),
    .head_raddr_i (head_raddr),
    .tail_raddr_i (tail_raddr),
    .head_rdata_o (head_rd),
    .tail_rdata_o (tail_rd)
  );

  // Accept a request only while the sequencer rests
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Decode the incoming slot and clamp the priority to the top level
  assign in_slot = SlotW'(in_data_i.task_id);
  assign in_ok   = (32'(in_data_i.task_id) < 32'(TASK_SLOTS));
  assign in_prio = (32'(in_data_i.priority_req) >= 32'(PRIORITY_LEVELS)) ?
                   PrioW'(PRIORITY_LEVELS - 1) : PrioW'(in_data_i.priority_req);

  // Highest nonempty queue
  always_comb begin
    top_prio = '0;
    for (int p = 0; p < PRIORITY_LEVELS; p++) begin
      if (ready_bits_q[p]) begin
        top_prio = PrioW'(p);
      end
    end
  end

  always_comb begin
    state_d       = state_q;
    req_d         = req_q;
    res_d         = res_q;
    out_d         = out_q;
    out_valid_d   = out_valid_q;
    op_t_d        = op_t_q;
    op_p_d        = op_p_q;
    pick_d        = pick_q;
    sched_d       = sched_q;
    ready_bits_d  = ready_bits_q;
    slot_ready_d  = slot_ready_q;
    cur_d         = cur_q;
    cur_present_d = cur_present_q;

    slot_we    = '0;
    next_waddr = op_t_q;
    next_wdata = '0;
    pp_waddr   = op_t_q;
    prev_wdata = '0;
    prio_wdata = op_p_q;
    slot_raddr = op_t_q;
    queue_we   = '0;
    head_waddr = op_p_q;
    head_wdata = op_t_q;
    tail_waddr = op_p_q;
    tail_wdata = op_t_q;
    head_raddr = top_prio;
    tail_raddr = op_p_q;

    // Drop the output once the consumer takes it
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          req_d   = in_data_i;
          res_d   = '0;
          sched_d = 1'b0;
          op_t_d  = in_slot;
          op_p_d  = in_prio;
          state_d = ST_DONE;
          case (req_e'(in_data_i.req_type))
            REQ_ADD: begin
              if (in_ok && !slot_ready_q[in_slot]) begin
                res_d.accepted = 1'b1;
                state_d        = ST_ENQ_RD;
              end
            end
            REQ_REMOVE: begin
              if (in_ok && slot_ready_q[in_slot]) begin
                res_d.accepted = 1'b1;
                state_d        = ST_DEQ_RD;
              end
            end
            default: begin
              if (|ready_bits_q) begin
                state_d = ST_PICK_RD;
              end
            end
          endcase
        end
      end

      ST_ENQ_RD: begin
        // New tail: terminate its next link, fetch the old tail
        slot_we.next_we = 1'b1;
        next_waddr      = op_t_q;
        next_wdata      = '0;
        tail_raddr      = op_p_q;
        state_d         = ST_ENQ_WR;
      end

      ST_ENQ_WR: begin
        slot_we.prev_we = 1'b1;
        slot_we.prio_we = 1'b1;
        pp_waddr        = op_t_q;
        prio_wdata      = op_p_q;
        if (ready_bits_q[op_p_q]) begin
          prev_wdata      = {1'b1, tail_rd};
          slot_we.next_we = 1'b1;
          next_waddr      = tail_rd;
          next_wdata      = {1'b1, op_t_q};
        end else begin
          prev_wdata       = '0;
          queue_we.head_we = 1'b1;
          head_waddr       = op_p_q;
          head_wdata       = op_t_q;
        end
        queue_we.tail_we       = 1'b1;
        tail_waddr             = op_p_q;
        tail_wdata             = op_t_q;
        ready_bits_d[op_p_q]   = 1'b1;
        slot_ready_d[op_t_q]   = 1'b1;
        if (sched_q) begin
          op_t_d  = pick_q;
          state_d = ST_DEQ_RD;
        end else begin
          state_d = ST_DONE;
        end
      end

      ST_DEQ_RD: begin
        slot_raddr = op_t_q;
        state_d    = ST_DEQ_WR;
      end

      ST_DEQ_WR: begin
        // Unlink: bridge the neighbors or move head/tail
        if (prev_rd[SlotW]) begin
          slot_we.next_we = 1'b1;
          next_waddr      = prev_rd[SlotW-1:0];
          next_wdata      = next_rd;
        end else begin
          queue_we.head_we = 1'b1;
          head_waddr       = prio_rd;
          head_wdata       = next_rd[SlotW-1:0];
        end
        if (next_rd[SlotW]) begin
          slot_we.prev_we = 1'b1;
          pp_waddr        = next_rd[SlotW-1:0];
          prev_wdata      = prev_rd;
        end else begin
          queue_we.tail_we = 1'b1;
          tail_waddr       = prio_rd;
          tail_wdata       = prev_rd[SlotW-1:0];
        end
        if (!prev_rd[SlotW] && !next_rd[SlotW]) begin
          ready_bits_d[prio_rd] = 1'b0;
        end
        slot_ready_d[op_t_q] = 1'b0;
        if (sched_q) begin
          res_d.switched       = 1'b1;
          res_d.previous_valid = cur_present_q;
          res_d.previous_task  = cur_present_q ? TaskW'(cur_q) : '0;
          cur_d                = op_t_q;
          cur_present_d        = 1'b1;
        end
        state_d = ST_DONE;
      end

      ST_PICK_RD: begin
        // Fetch the top head and the current task's stored priority
        head_raddr = top_prio;
        slot_raddr = cur_q;
        state_d    = ST_PICK_DEC;
      end

      ST_PICK_DEC: begin
        res_d.accepted     = 1'b1;
        res_d.chosen_valid = 1'b1;
        res_d.chosen_task  = TaskW'(head_rd);
        pick_d             = head_rd;
        state_d            = ST_DONE;
        if (req_e'(req_q.req_type) == REQ_SCHED &&
            !(cur_present_q && cur_q == head_rd)) begin
          sched_d = 1'b1;
          if (cur_present_q && req_q.current_runs && !slot_ready_q[cur_q]) begin
            op_t_d  = cur_q;
            op_p_d  = prio_rd;
            state_d = ST_ENQ_RD;
          end else begin
            op_t_d  = head_rd;
            state_d = ST_DEQ_RD;
          end
        end
      end

      ST_DONE: begin
        // Hold the result here until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_d            = res_q;
          out_d.ready_mask = MaskW'(ready_bits_q);
          out_valid_d      = 1'b1;
          state_d          = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      out_valid_q   <= 1'b0;
      ready_bits_q  <= '0;
      slot_ready_q  <= '0;
      cur_q         <= '0;
      cur_present_q <= 1'b0;
      sched_q       <= 1'b0;
    end else begin
      state_q       <= state_d;
      out_valid_q   <= out_valid_d;
      ready_bits_q  <= ready_bits_d;
      slot_ready_q  <= slot_ready_d;
      cur_q         <= cur_d;
      cur_present_q <= cur_present_d;
      sched_q       <= sched_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    res_q  <= res_d;
    out_q  <= out_d;
    op_t_q <= op_t_d;
    op_p_q <= op_p_d;
    pick_q <= pick_d;
  end

  // Assertions
  a_state_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_empty_bitmap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ready_bits_q == '0) |-> (slot_ready_q == '0))
    else $error("ready slot present with empty bitmap");

  a_switch_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.switched) |->
      (out_data_o.accepted && out_data_o.chosen_valid))
    else $error("switch reported without a chosen task");

  a_done_delivers : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && !(out_valid_o && out_stall_i)) |=>
      (out_valid_o && state_q == ST_IDLE))
    else $error("result not delivered from done state");

endmodule

@@ verif/tb_priority_ready_queue_scheduler_top.sv @@
// ----------------------------------------------------------------------------
// tb_priority_ready_queue_scheduler_top: ready-queue scheduler testbench
// Drives add, remove, peek and schedule requests with random idling on both
// channels, predicts every result from a behavioral queue model and checks it.
// ----------------------------------------------------------------------------

// Scoreboard: holds a copy of the scheduler state and the pending results.
class sched_scoreboard;
  localparam int Levels = 32;
  localparam int Slots  = 64;
  localparam int NoLink = -1;

  int              head_q[Levels];
  int              tail_q[Levels];
  logic [31:0]     nonempty;
  int              nxt[Slots];
  int              prv[Slots];
  int              prio_of[Slots];
  bit              is_ready[Slots];
  int              cur;
  bit              cur_ok;
  prqs_pkg::out_t  pending[$];
  int              errors;

  function new();
    nonempty = '0;
    cur = 0;
    cur_ok = 0;
    errors = 0;
    foreach (is_ready[i]) is_ready[i] = 0;
  endfunction

  function bit link_task(int t, int p);
    if (is_ready[t]) return 0;
    if (p > Levels - 1) p = Levels - 1;
    nxt[t] = NoLink;
    if (nonempty[p]) begin
      prv[t] = tail_q[p];
      nxt[tail_q[p]] = t;
    end else begin
      prv[t] = NoLink;
      head_q[p] = t;
      nonempty[p] = 1'b1;
    end
    tail_q[p] = t;
    prio_of[t] = p;
    is_ready[t] = 1;
    return 1;
  endfunction

  function bit unlink_task(int t);
    int p;
    p = prio_of[t];
    if (!is_ready[t]) return 0;
    if (prv[t] != NoLink) nxt[prv[t]] = nxt[t];
    else head_q[p] = nxt[t];
    if (nxt[t] != NoLink) prv[nxt[t]] = prv[t];
    else tail_q[p] = prv[t];
    if (prv[t] == NoLink && nxt[t] == NoLink) nonempty[p] = 1'b0;
    is_ready[t] = 0;
    return 1;
  endfunction

  function bit top_head(output int t);
    t = 0;
    for (int p = Levels - 1; p >= 0; p--) begin
      if (nonempty[p]) begin
        t = head_q[p];
        return 1;
      end
    end
    return 0;
  endfunction

  // Note an accepted request: advance the state and queue its result.
  function void note_request(prqs_pkg::in_t rq);
    prqs_pkg::out_t r;
    int pick;
    r = '0;
    case (rq.req_type)
      prqs_pkg::REQ_ADD: begin
        r.accepted = link_task(int'(rq.task_id), int'(rq.priority_req));
      end
      prqs_pkg::REQ_REMOVE: begin
        r.accepted = unlink_task(int'(rq.task_id));
      end
      default: begin
        if (top_head(pick)) begin
          r.accepted = 1;
          r.chosen_valid = 1;
          r.chosen_task = 6'(pick);
          if (rq.req_type == prqs_pkg::REQ_SCHED && !(cur_ok && cur == pick)) begin
            if (cur_ok && rq.current_runs) void'(link_task(cur, prio_of[cur]));
            void'(unlink_task(pick));
            r.previous_valid = cur_ok;
            r.previous_task = cur_ok ? 6'(cur) : 6'd0;
            cur = pick;
            cur_ok = 1;
            r.switched = 1;
          end
        end
      end
    endcase
    r.ready_mask = nonempty;
    pending.push_back(r);
  endfunction

  // Check one result against the oldest pending one.
  function void check_result(prqs_pkg::out_t got);
    prqs_pkg::out_t exp_r;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      errors++;
      return;
    end
    exp_r = pending.pop_front();
    if (got.accepted !== exp_r.accepted ||
        got.chosen_valid !== exp_r.chosen_valid ||
        got.chosen_task !== exp_r.chosen_task ||
        got.switched !== exp_r.switched ||
        got.previous_valid !== exp_r.previous_valid ||
        got.previous_task !== exp_r.previous_task ||
        got.ready_mask !== exp_r.ready_mask) begin
      $display("%0t: mismatch expected %h actual %h", $time, exp_r, got);
      errors++;
    end
  endfunction
endclass

module tb_priority_ready_queue_scheduler_top;
  import prqs_pkg::*;

  localparam int WatchdogLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  sched_scoreboard sb = new();
  int  idle_cycles = 0;
  int  sent = 0;
  int  results_seen = 0;
  int  switches_seen = 0;
  bit  stim_done = 0;

  always #1 clk_i = ~clk_i;

  priority_ready_queue_scheduler_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // No gap half the time, otherwise mostly a short gap and now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Send one request transaction and wait for its acceptance.
  task automatic send_req(req_e kind, int tid, int prio, bit runs);
    in_t rq;
    rq.req_type = kind;
    rq.task_id = TaskW'(tid);
    rq.priority_req = PrioReqW'(prio);
    rq.current_runs = runs;
    in_valid_i <= 1'b1;
    in_data_i <= rq;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(rq);
    sent++;
    repeat (gap_len()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Keep a small pool of tasks most of the time so queues get deep.
  task automatic random_req(int pool);
    int r;
    r = $urandom_range(0, 99);
    if (r < 40)
      send_req(REQ_ADD, $urandom_range(0, pool - 1),
               ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                           : $urandom_range(0, 7),
               1'($urandom_range(0, 1)));
    else if (r < 55)
      send_req(REQ_REMOVE, $urandom_range(0, pool - 1), $urandom_range(0, 255),
               1'($urandom_range(0, 1)));
    else if (r < 65)
      send_req(REQ_PEEK, $urandom_range(0, 63), $urandom_range(0, 255),
               1'($urandom_range(0, 1)));
    else
      send_req(REQ_SCHED, $urandom_range(0, 63), $urandom_range(0, 255),
               $urandom_range(0, 3) != 0);
  endtask

  // Stimulus: directed corners, then random traffic.
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Empty queues: peek and schedule find nothing, removes are ignored.
    send_req(REQ_PEEK, 0, 0, 0);
    send_req(REQ_SCHED, 0, 0, 1);
    send_req(REQ_REMOVE, 63, 0, 0);
    // Extremes of slot and priority, a clamp above the top level, a duplicate add.
    send_req(REQ_ADD, 0, 0, 0);
    send_req(REQ_ADD, 63, 255, 1);
    send_req(REQ_ADD, 63, 3, 0);
    send_req(REQ_ADD, 21, 31, 0);
    send_req(REQ_ADD, 42, 170, 0);
    send_req(REQ_ADD, 5, 85, 1);
    send_req(REQ_PEEK, 0, 0, 0);
    // First schedule with no current task, then one whose current task is already ready.
    send_req(REQ_SCHED, 0, 0, 1);
    send_req(REQ_ADD, 63, 31, 0);
    send_req(REQ_SCHED, 0, 0, 1);
    // Requeue of a running current task, then a current that is not running.
    send_req(REQ_SCHED, 0, 0, 1);
    send_req(REQ_ADD, 21, 31, 0);
    send_req(REQ_REMOVE, 42, 0, 0);
    send_req(REQ_SCHED, 0, 0, 1);
    send_req(REQ_SCHED, 0, 0, 0);
    send_req(REQ_REMOVE, 0, 0, 0);
    send_req(REQ_REMOVE, 5, 0, 0);
    send_req(REQ_REMOVE, 5, 0, 0);
    for (int i = 0; i < 950; i++) random_req((i % 200 < 150) ? 12 : 64);
    in_valid_i <= 1'b0;
    stim_done = 1;
  end

  // Result side: random stall, check each accepted result transaction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        sb.check_result(out_data_o);
        results_seen++;
        if (out_data_o.switched) switches_seen++;
      end
      out_stall_i <= (gap_len() != 0);
    end
  end

  // Watchdog and end of run.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog expired with %0d results pending", sb.pending.size());
      $display("priority_ready_queue_scheduler_top verification failed");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("covered %0d requests, %0d results, %0d task switches",
             sent, results_seen, switches_seen);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("priority_ready_queue_scheduler_top verification clean");
    else
      $display("priority_ready_queue_scheduler_top verification failed");
    $finish;
  end
endmodule
